@@ design/halo_tile_address_mapper_core_defines.svh @@
// Assertion macros shared by the halo tile address mapper RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef HALO_TILE_ADDRESS_MAPPER_CORE_DEFINES_SVH
`define HALO_TILE_ADDRESS_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define HATM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define HATM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hatm_pkg.sv @@
// Package for the halo tile address mapper: field widths, register codes,
// payload structs and small helper functions. No dependencies.
`timescale 1ns / 1ps

package hatm_pkg;

    // field widths
    localparam int TN_W       = 20;
    localparam int LOC_W      = 10;
    localparam int NT_W       = 7;
    localparam int TS_W       = 11;
    localparam int HALO_W     = 8;
    localparam int SUB_W      = 11;
    localparam int GRID_W     = 13;
    localparam int GI_W       = 36;
    localparam int BO_W       = 50;
    localparam int ELEM_SHIFT = 2;           // float32 element: 4 bytes
    localparam int SPAN_W     = SUB_W + 1;   // halo + subtile fits here
    localparam int PROD_W     = NT_W + SUB_W;
    localparam int DIV_STEP   = 4;           // quotient bits per divider stage

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_AXIS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALO_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBTILE_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE      = 3'd4;

    typedef struct packed {
        logic [NT_W-1:0]   tiles_per_axis;
        logic [TS_W-1:0]   tile_size;
        logic [HALO_W-1:0] halo_width;
        logic [SUB_W-1:0]  subtile_size;
        logic [GRID_W-1:0] grid_size;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        tiles_per_axis: 7'd1,
        tile_size:      11'd64,
        halo_width:     8'd0,
        subtile_size:   11'd64,
        grid_size:      13'd64
    };

    typedef struct packed {
        logic [TN_W-1:0]  tile_number;
        logic [LOC_W-1:0] local_x;
        logic [LOC_W-1:0] local_y;
        logic [LOC_W-1:0] local_z;
    } t_in;

    typedef struct packed {
        logic [GI_W-1:0] global_index;
        logic [BO_W-1:0] byte_offset;
        logic            in_interior;
        logic            bad_tile;
    } t_out;

    // pipeline stages of a restoring divider over a w-bit dividend
    function automatic int div_stages(int w);
        return (w + DIV_STEP - 1) / DIV_STEP;
    endfunction

    // dividend width of the per-axis wrap: tix*sub + local + (grid << HALO_W)
    function automatic int axis_dvd_w(int mgb);
        return (((mgb + 1 + HALO_W) > (PROD_W + 1)) ? (mgb + 1 + HALO_W) : (PROD_W + 1)) + 1;
    endfunction

    // halo <= l < halo + subtile
    function automatic logic in_span(logic [LOC_W-1:0] l, logic [HALO_W-1:0] h,
                                     logic [SUB_W-1:0] s);
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
        logic [SPAN_W-1:0] lv;
        lo = SPAN_W'(h);
        hi = SPAN_W'(h) + SPAN_W'(s);
        lv = SPAN_W'(l);
        return (lv >= lo) && (lv < hi);
    endfunction

endpackage

@@ design/hatm_dly.sv @@
// Fixed-length register delay line used to align side data with the pipeline.
// Depends on nothing.
`timescale 1ns / 1ps

module hatm_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (N == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_sr
            logic [W-1:0] r_sr [N];

            always_ff @(posedge i_clk) begin
                r_sr[0] <= i_d;
                for (int k = 1; k < N; k++) begin
                    r_sr[k] <= r_sr[k-1];
                end
            end

            assign o_q = r_sr[N-1];
        end
    endgenerate

endmodule

@@ design/hatm_div.sv @@
// Pipelined restoring divider, STEP quotient bits per register stage.
// Imports hatm_pkg; the stage count is computed locally.
`timescale 1ns / 1ps

module hatm_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 7,
    parameter int STEP  = 4
) (
    input  logic             i_clk,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic [DVD_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rem
);
    import hatm_pkg::*;

    localparam int NSTG = (DVD_W + STEP - 1) / STEP;

    // r_wrk: unused dividend bits on top, quotient bits shifting in below
    logic [DVD_W-1:0] r_wrk [NSTG];
    logic [DVS_W-1:0] r_rem [NSTG];
    logic [DVD_W-1:0] a_wrk [NSTG];
    logic [DVS_W-1:0] a_rem [NSTG];
    logic [DVD_W-1:0] n_wrk [NSTG];
    logic [DVS_W-1:0] n_rem [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            if (s == 0) begin : g_first
                assign a_wrk[s] = i_dvd;
                assign a_rem[s] = '0;
            end else begin : g_next
                assign a_wrk[s] = r_wrk[s-1];
                assign a_rem[s] = r_rem[s-1];
            end

            always_comb begin
                logic [DVD_W-1:0] wrk;
                logic [DVS_W-1:0] rem;
                logic [DVS_W:0]   trial;
                wrk   = a_wrk[s];
                rem   = a_rem[s];
                trial = '0;
                for (int k = 0; k < STEP; k++) begin
                    if (s * STEP + k < DVD_W) begin
                        trial = {rem, wrk[DVD_W-1]};
                        wrk   = {wrk[DVD_W-2:0], 1'b0};
                        if (trial >= {1'b0, i_dvs}) begin
                            trial  = trial - {1'b0, i_dvs};
                            wrk[0] = 1'b1;
                        end
                        rem = trial[DVS_W-1:0];
                    end
                end
                n_wrk[s] = wrk;
                n_rem[s] = rem;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            r_wrk[k] <= n_wrk[k];
            r_rem[k] <= n_rem[k];
        end
    end

    assign o_quo = r_wrk[NSTG-1];
    assign o_rem = r_rem[NSTG-1];

endmodule

@@ design/hatm_axis.sv @@
// One axis of the periodic wrap: g = (tix*sub + local - halo) mod grid.
// Depends on hatm_pkg and hatm_div.
`timescale 1ns / 1ps

module hatm_axis #(
    parameter int MAX_GRID_BITS = 12
) (
    input  logic                         i_clk,
    input  logic [hatm_pkg::NT_W-1:0]    i_tix,
    input  logic [hatm_pkg::LOC_W-1:0]   i_local,
    input  hatm_pkg::t_cfg               i_cfg,
    input  logic [MAX_GRID_BITS:0]       i_grid,
    output logic [MAX_GRID_BITS:0]       o_coord
);
    import hatm_pkg::*;

    localparam int GW = MAX_GRID_BITS + 1;
    localparam int AW = axis_dvd_w(MAX_GRID_BITS);

    logic [PROD_W-1:0] r_prod;
    logic [AW-1:0]     r_bias;
    logic [AW-1:0]     r_sum;

    // grid << HALO_W exceeds any halo, so the dividend never goes negative
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_tix) * PROD_W'(i_cfg.subtile_size);
        r_bias <= AW'(i_local) + (AW'(i_grid) << HALO_W) - AW'(i_cfg.halo_width);
        r_sum  <= AW'(r_prod) + r_bias;
    end

    hatm_div #(
        .DVD_W (AW),
        .DVS_W (GW),
        .STEP  (DIV_STEP)
    ) u_mod (
        .i_clk (i_clk),
        .i_dvd (r_sum),
        .i_dvs (i_grid),
        .o_quo (),
        .o_rem (o_coord)
    );

endmodule

@@ design/hatm_boff.sv @@
// Byte offset in tile-major float32 layout, three-stage Horner chain:
// ((idx*T + lz)*T + ly)*T + lx, scaled by 4. Depends on hatm_pkg.
`timescale 1ns / 1ps

module hatm_boff #(
    parameter int MAX_TILE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic [hatm_pkg::TN_W-1:0]   i_idx0,
    input  logic [hatm_pkg::LOC_W-1:0]  i_lx,
    input  logic [hatm_pkg::LOC_W-1:0]  i_ly,
    input  logic [hatm_pkg::LOC_W-1:0]  i_lz,
    input  logic [MAX_TILE_BITS:0]      i_tsz,
    output logic [hatm_pkg::BO_W-1:0]   o_offset
);
    import hatm_pkg::*;

    localparam int TW  = MAX_TILE_BITS + 1;
    localparam int B1W = TN_W + TW + 1;
    localparam int IW  = BO_W - ELEM_SHIFT;   // element index, kept mod 2^IW

    logic [B1W-1:0]   r_b1;
    logic [IW-1:0]    r_b2;
    logic [IW-1:0]    r_b3;
    logic [LOC_W-1:0] r_ly1;
    logic [LOC_W-1:0] r_lx1;
    logic [LOC_W-1:0] r_lx2;

    always_ff @(posedge i_clk) begin
        r_b1  <= B1W'(i_idx0) * B1W'(i_tsz) + B1W'(i_lz);
        r_ly1 <= i_ly;
        r_lx1 <= i_lx;
        r_b2  <= IW'(r_b1) * IW'(i_tsz) + IW'(r_ly1);
        r_lx2 <= r_lx1;
        r_b3  <= r_b2 * IW'(i_tsz) + IW'(r_lx2);
    end

    assign o_offset = {r_b3, {ELEM_SHIFT{1'b0}}};

endmodule

@@ design/halo_tile_address_mapper_core.sv @@
// Halo tile address mapper, top level: config registers, tile index
// dividers, three axis wrap units, byte offset chain and result register.
// Depends on hatm_pkg, hatm_dly, hatm_div, hatm_axis, hatm_boff, defines header.
//
//   channel   direction  handshake                       payload
//   --------  ---------  ------------------------------  ---------------------
//   item in   input      start & !busy at clock edge     i_item   (t_in)
//   result    output     o_valid, one cycle, no stall    o_result (t_out)
//   config    input      i_cfg_we at clock edge          i_cfg_idx, i_cfg_data
//
// Throughput is one item per clock; busy is only high in reset and the cycle after it.
// The three chained restoring dividers (4 bits per stage) set the pipeline depth.
// Reset is synchronous, active low; it empties the valid pipe and loads the register
// defaults. Results cannot be held off, so there is no stall path.
`timescale 1ns / 1ps
`include "halo_tile_address_mapper_core_defines.svh"

module halo_tile_address_mapper_core #(
    parameter int MAX_GRID_BITS = 12,
    parameter int MAX_TILE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              start,
    output logic                              busy,
    input  hatm_pkg::t_in                     i_item,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [hatm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hatm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // result channel
    output logic                              o_valid,
    output hatm_pkg::t_out                    o_result
);
    import hatm_pkg::*;

    // ------------------------------------------------------------------
    // Widths and pipeline timing. Stages are numbered in order from the
    // input register, which is stage 0.
    // ------------------------------------------------------------------
    localparam int GW     = MAX_GRID_BITS + 1;          // effective grid
    localparam int TW     = MAX_TILE_BITS + 1;          // effective tile size
    localparam int GCW    = (GW > GRID_W) ? GW : GRID_W;
    localparam int TCW    = (TW > TS_W) ? TW : TS_W;
    localparam int QB_W   = 2 * NT_W;                   // y/z tile quotient
    localparam int NT2_W  = 2 * NT_W;
    localparam int NT3_W  = 3 * NT_W;
    localparam int G2W    = 2 * GW;
    localparam int G3W    = 3 * GW;
    localparam int NA     = div_stages(TN_W);
    localparam int NB     = div_stages(QB_W);
    localparam int NC     = div_stages(axis_dvd_w(MAX_GRID_BITS));
    localparam int KB     = 1 + NA + NB;                // tile indices ready
    localparam int KG     = KB + 2 + NC;                // global coords ready
    localparam int KO     = KG + 3;                     // result register
    localparam int BOFF_K = 4;                          // byte offset ready

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    t_cfg          r_cfg;
    logic          r_busy;
    logic [KO:0]   r_vld;     // valid bit of every stage
    logic          acc;

    assign acc  = start && !busy;
    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_RESET;
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[KO-1:0], acc};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TILES_PER_AXIS: r_cfg.tiles_per_axis <= i_cfg_data[NT_W-1:0];
                    CFG_TILE_SIZE:      r_cfg.tile_size      <= i_cfg_data[TS_W-1:0];
                    CFG_HALO_WIDTH:     r_cfg.halo_width     <= i_cfg_data[HALO_W-1:0];
                    CFG_SUBTILE_SIZE:   r_cfg.subtile_size   <= i_cfg_data[SUB_W-1:0];
                    CFG_GRID_SIZE:      r_cfg.grid_size      <= i_cfg_data[GRID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Values derived from the registers. They are registered behind the
    // config registers, r_nt3 behind r_nt2; only later stages read them.
    // ------------------------------------------------------------------
    logic [GCW-1:0]   grid_c;
    logic [GCW-1:0]   grid_max;
    logic [GCW-1:0]   grid_sel;
    logic [TCW-1:0]   tsz_c;
    logic [TCW-1:0]   tsz_max;
    logic [TCW-1:0]   tsz_sel;
    logic [GW-1:0]    r_geff;
    logic [TW-1:0]    r_tsz;
    logic [NT2_W-1:0] r_nt2;
    logic [NT3_W-1:0] r_nt3;

    // grid of zero acts as one; oversize grid and tile saturate
    always_comb begin
        grid_c   = GCW'(r_cfg.grid_size);
        grid_max = GCW'(1) << MAX_GRID_BITS;
        if (grid_c == '0) begin
            grid_sel = GCW'(1);
        end else if (grid_c > grid_max) begin
            grid_sel = grid_max;
        end else begin
            grid_sel = grid_c;
        end
        tsz_c   = TCW'(r_cfg.tile_size);
        tsz_max = TCW'(1) << MAX_TILE_BITS;
        tsz_sel = (tsz_c > tsz_max) ? tsz_max : tsz_c;
    end

    always_ff @(posedge i_clk) begin
        r_geff <= GW'(grid_sel);
        r_tsz  <= TW'(tsz_sel);
        r_nt2  <= NT2_W'(r_cfg.tiles_per_axis) * NT2_W'(r_cfg.tiles_per_axis);
        r_nt3  <= NT3_W'(r_nt2) * NT3_W'(r_cfg.tiles_per_axis);
    end

    // ------------------------------------------------------------------
    // Stages 0 and 1: capture the item, 0-based tile index, interior flag.
    // Only raw register values are used here, so a write in the same
    // cycle as the item is honored.
    // ------------------------------------------------------------------
    t_in              r_p1_item;
    logic [TN_W-1:0]  r_p2_idx0;
    logic [TN_W-1:0]  r_p2_tn;
    logic [LOC_W-1:0] r_p2_lx;
    logic [LOC_W-1:0] r_p2_ly;
    logic [LOC_W-1:0] r_p2_lz;
    logic             r_p2_in;

    always_ff @(posedge i_clk) begin
        r_p1_item <= i_item;
        r_p2_idx0 <= r_p1_item.tile_number - TN_W'(1);
        r_p2_tn   <= r_p1_item.tile_number;
        r_p2_lx   <= r_p1_item.local_x;
        r_p2_ly   <= r_p1_item.local_y;
        r_p2_lz   <= r_p1_item.local_z;
        r_p2_in   <= in_span(r_p1_item.local_x, r_cfg.halo_width, r_cfg.subtile_size)
                  && in_span(r_p1_item.local_y, r_cfg.halo_width, r_cfg.subtile_size)
                  && in_span(r_p1_item.local_z, r_cfg.halo_width, r_cfg.subtile_size);
    end

    // ------------------------------------------------------------------
    // Tile index split: idx0 / nt gives x index (remainder); the quotient
    // divided by nt again gives y (remainder) and z (quotient). On a bad
    // tile these are garbage and the result is forced to zero later.
    // ------------------------------------------------------------------
    logic [TN_W-1:0]  quo_a;
    logic [NT_W-1:0]  rem_a;
    logic [QB_W-1:0]  quo_b;
    logic [NT_W-1:0]  rem_b;
    logic [NT_W-1:0]  tix_x;

    hatm_div #(
        .DVD_W (TN_W),
        .DVS_W (NT_W),
        .STEP  (DIV_STEP)
    ) u_div_x (
        .i_clk (i_clk),
        .i_dvd (r_p2_idx0),
        .i_dvs (r_cfg.tiles_per_axis),
        .o_quo (quo_a),
        .o_rem (rem_a)
    );

    hatm_div #(
        .DVD_W (QB_W),
        .DVS_W (NT_W),
        .STEP  (DIV_STEP)
    ) u_div_yz (
        .i_clk (i_clk),
        .i_dvd (quo_a[QB_W-1:0]),
        .i_dvs (r_cfg.tiles_per_axis),
        .o_quo (quo_b),
        .o_rem (rem_b)
    );

    hatm_dly #(.W(NT_W), .N(NB)) u_dly_tx (
        .i_clk (i_clk),
        .i_d   (rem_a),
        .o_q   (tix_x)
    );

    // local coordinates ride along until the tile indices are ready
    logic [3*LOC_W-1:0] loc_d;

    hatm_dly #(.W(3 * LOC_W), .N(KB - 1)) u_dly_loc (
        .i_clk (i_clk),
        .i_d   ({r_p2_lx, r_p2_ly, r_p2_lz}),
        .o_q   (loc_d)
    );

    // ------------------------------------------------------------------
    // Periodic wrap, one unit per axis
    // ------------------------------------------------------------------
    logic [GW-1:0] gx;
    logic [GW-1:0] gy;
    logic [GW-1:0] gz;

    hatm_axis #(.MAX_GRID_BITS(MAX_GRID_BITS)) u_axis_x (
        .i_clk   (i_clk),
        .i_tix   (tix_x),
        .i_local (loc_d[3*LOC_W-1:2*LOC_W]),
        .i_cfg   (r_cfg),
        .i_grid  (r_geff),
        .o_coord (gx)
    );

    hatm_axis #(.MAX_GRID_BITS(MAX_GRID_BITS)) u_axis_y (
        .i_clk   (i_clk),
        .i_tix   (rem_b),
        .i_local (loc_d[2*LOC_W-1:LOC_W]),
        .i_cfg   (r_cfg),
        .i_grid  (r_geff),
        .o_coord (gy)
    );

    hatm_axis #(.MAX_GRID_BITS(MAX_GRID_BITS)) u_axis_z (
        .i_clk   (i_clk),
        .i_tix   (quo_b[NT_W-1:0]),
        .i_local (loc_d[LOC_W-1:0]),
        .i_cfg   (r_cfg),
        .i_grid  (r_geff),
        .o_coord (gz)
    );

    // linear index, Horner form: (gz*G + gy)*G + gx
    logic [G2W-1:0] r_gi1;
    logic [G3W-1:0] r_gi2;
    logic [GW-1:0]  r_gx_d;

    always_ff @(posedge i_clk) begin
        r_gi1  <= G2W'(gz) * G2W'(r_geff) + G2W'(gy);
        r_gx_d <= gx;
        r_gi2  <= G3W'(r_gi1) * G3W'(r_geff) + G3W'(r_gx_d);
    end

    // ------------------------------------------------------------------
    // Byte offset runs beside the dividers and waits for the index
    // ------------------------------------------------------------------
    logic [BO_W-1:0] boff;
    logic [BO_W-1:0] boff_d;

    hatm_boff #(.MAX_TILE_BITS(MAX_TILE_BITS)) u_boff (
        .i_clk    (i_clk),
        .i_idx0   (r_p2_idx0),
        .i_lx     (r_p2_lx),
        .i_ly     (r_p2_ly),
        .i_lz     (r_p2_lz),
        .i_tsz    (r_tsz),
        .o_offset (boff)
    );

    hatm_dly #(.W(BO_W), .N(KG + 2 - BOFF_K)) u_dly_boff (
        .i_clk (i_clk),
        .i_d   (boff),
        .o_q   (boff_d)
    );

    // tile number and interior flag for the final check
    logic [TN_W-1:0] tn_d;
    logic            in_d;

    hatm_dly #(.W(TN_W + 1), .N(KG + 1)) u_dly_tn (
        .i_clk (i_clk),
        .i_d   ({r_p2_tn, r_p2_in}),
        .o_q   ({tn_d, in_d})
    );

    // ------------------------------------------------------------------
    // Result register: range check of the tile number, zeroing on a bad
    // tile, masking of the linear index to its field width.
    // ------------------------------------------------------------------
    logic [G3W+GI_W-1:0] gi_ext;
    logic                bad;
    t_out                n_res;
    t_out                r_res;

    always_comb begin
        gi_ext = {{GI_W{1'b0}}, r_gi2};
        bad    = (tn_d == '0) || ({1'b0, tn_d} > NT3_W'(r_nt3));
        n_res.bad_tile     = bad;
        n_res.in_interior  = !bad && in_d;
        n_res.global_index = bad ? '0 : gi_ext[GI_W-1:0];
        n_res.byte_offset  = bad ? '0 : boff_d;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_vld[KO];
    assign o_result = r_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HATM_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n,
        o_valid && o_result.bad_tile,
        (o_result.global_index == '0) && (o_result.byte_offset == '0) && !o_result.in_interior,
        "bad tile result carries nonzero payload")

    `HATM_ASSERT_NEXT(a_busy_release, i_clk, i_rst_n,
        i_rst_n,
        !busy,
        "busy still high one cycle after reset release")

endmodule
